// ===== src/bse_pkg.sv =====
// shared constants, types and state codes for the bubble sort engine
package bse_pkg;

   localparam int MAX_ITEMS = 32;
   localparam int ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int DATA_W    = 32;

   typedef logic signed [DATA_W-1:0] word_type;

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_PASS_START,
      ST_PASS_LOAD,
      ST_PASS_RUN,
      ST_PASS_END,
      ST_EMIT_ADDR,
      ST_EMIT_LOAD
   } state_type;

   // result of one compare-and-swap step
   typedef struct packed {
      logic     gt;
      word_type low_word;
      word_type high_word;
   } cmp_type;

endpackage

// ===== src/bse_cmp_swap.sv =====
// shared compare-and-swap unit: orders the carried word against the word just read
module bse_cmp_swap (
   input  bse_pkg::word_type carry_word,
   input  bse_pkg::word_type read_word,
   output bse_pkg::cmp_type  result
);
   import bse_pkg::*;

   // strict signed greater-than, equal words keep their order
   always_comb begin
      result.gt = carry_word > read_word;
      if (result.gt) begin
         result.low_word  = read_word;
         result.high_word = carry_word;
      end else begin
         result.low_word  = carry_word;
         result.high_word = read_word;
      end
   end

endmodule

// ===== src/bubble_sort_engine_top.sv =====
// bubble sort engine: collects a set of words, sorts them in place, streams them out
// collect: one word per cycle; the last word starts the sort (words past capacity dropped)
// sort: each pass over limit words goes through one comparator, one store read port and
//   one store write port; at most n-1 passes, fewer once a pass makes no swap
// emit: each word is read from the store, then loaded into the result register once free
// reset clears the sequencer, counts, flags and result valid; store contents are not cleared
module bubble_sort_engine_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [31:0]       req_item_value,
   input  logic                     req_item_last,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [31:0]       rsp_sorted_value,
   output logic                     rsp_sorted_last,
   output logic                     rsp_overflow
);
   import bse_pkg::*;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     limit_ff, limit_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic                 dropped_ff, dropped_in;
   logic                 swapped_ff, swapped_in;
   word_type             carry_ff, carry_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   word_type             rsp_value_ff, rsp_value_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;

   word_type             store_mem [MAX_ITEMS];
   word_type             rd_ff;
   logic [ADDR_W-1:0]    rd_addr;
   logic [ADDR_W-1:0]    wr_addr;
   word_type             wr_data;
   logic                 wr_en;

   logic                 req_accept;
   logic                 store_full;
   logic [CNT_W-1:0]     count_next;
   logic [CNT_W-1:0]     idx_inc;
   logic [CNT_W-1:0]     lim_m1;
   logic                 out_free;
   cmp_type              cmp;

   assign req_accept = req_valid && !req_stall;
   assign store_full = (count_ff == CNT_W'(MAX_ITEMS));
   assign count_next = store_full ? count_ff : CNT_W'(count_ff + 1'b1);
   assign idx_inc    = CNT_W'(idx_ff + 1'b1);
   assign lim_m1     = CNT_W'(limit_ff - 1'b1);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   bse_cmp_swap u_cmp (
      .carry_word (carry_ff),
      .read_word  (rd_ff),
      .result     (cmp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_COLLECT: begin
            if (req_accept && req_item_last) begin
               state_in = (count_next < CNT_W'(2)) ? ST_EMIT_ADDR : ST_PASS_START;
            end
         end
         ST_PASS_START: state_in = ST_PASS_LOAD;
         ST_PASS_LOAD:  state_in = ST_PASS_RUN;
         ST_PASS_RUN: begin
            if (idx_inc == limit_ff) begin
               state_in = ST_PASS_END;
            end
         end
         ST_PASS_END: begin
            state_in = (swapped_ff && limit_ff > CNT_W'(2)) ? ST_PASS_START : ST_EMIT_ADDR;
         end
         ST_EMIT_ADDR: begin
            state_in = (idx_ff == count_ff) ? ST_COLLECT : ST_EMIT_LOAD;
         end
         ST_EMIT_LOAD: begin
            if (out_free) begin
               state_in = (idx_inc == count_ff) ? ST_COLLECT : ST_EMIT_ADDR;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   // datapath and store port control
   always_comb begin
      count_in     = count_ff;
      limit_in     = limit_ff;
      idx_in       = idx_ff;
      dropped_in   = dropped_ff;
      swapped_in   = swapped_ff;
      carry_in     = carry_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rd_addr      = idx_ff[ADDR_W-1:0];
      wr_addr      = count_ff[ADDR_W-1:0];
      wr_data      = req_item_value;
      wr_en        = 1'b0;
      req_stall    = 1'b1;
      case (state_ff)
         // store incoming words in arrival order
         ST_COLLECT: begin
            req_stall = 1'b0;
            if (req_accept) begin
               wr_en      = !store_full;
               count_in   = count_next;
               dropped_in = dropped_ff || store_full;
               if (req_item_last) begin
                  limit_in = count_next;
                  idx_in   = '0;
               end
            end
         end
         // fetch the first word of the pass
         ST_PASS_START: begin
            rd_addr    = '0;
            swapped_in = 1'b0;
         end
         // first word becomes the carry, fetch the second
         ST_PASS_LOAD: begin
            carry_in = rd_ff;
            rd_addr  = ADDR_W'(1);
            idx_in   = CNT_W'(1);
         end
         // write back the smaller word one slot down, carry the larger
         ST_PASS_RUN: begin
            wr_en      = 1'b1;
            wr_addr    = lim_m1[ADDR_W-1:0];
            wr_addr    = CNT_W'(idx_ff - 1'b1) < CNT_W'(MAX_ITEMS) ?
                         ADDR_W'(idx_ff - 1'b1) : '0;
            wr_data    = cmp.low_word;
            carry_in   = cmp.high_word;
            swapped_in = swapped_ff || cmp.gt;
            rd_addr    = idx_inc[ADDR_W-1:0];
            idx_in     = idx_inc;
         end
         // the largest word of the pass lands at its end
         ST_PASS_END: begin
            wr_en    = 1'b1;
            wr_addr  = lim_m1[ADDR_W-1:0];
            wr_data  = carry_ff;
            limit_in = lim_m1;
            idx_in   = '0;
         end
         // read the next sorted word
         ST_EMIT_ADDR: begin
            if (idx_ff == count_ff) begin
               count_in   = '0;
               dropped_in = 1'b0;
            end
         end
         // hand the word to the result register when it is free
         ST_EMIT_LOAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_ff;
               rsp_last_in  = (idx_inc == count_ff);
               rsp_ovf_in   = dropped_ff;
               idx_in       = idx_inc;
               if (idx_inc == count_ff) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
               end
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // value store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_ff <= store_mem[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         count_ff     <= '0;
         limit_ff     <= '0;
         idx_ff       <= '0;
         dropped_ff   <= 1'b0;
         swapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         limit_ff     <= limit_in;
         idx_ff       <= idx_in;
         dropped_ff   <= dropped_in;
         swapped_ff   <= swapped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      carry_ff     <= carry_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_sorted_last  = rsp_last_ff;
   assign rsp_overflow     = rsp_ovf_ff;

endmodule
